/* hw/rtl/aes128_pkg.sv */
// ----------------------------------------------------------------------------
// aes128_pkg
// Types, constants and round functions shared by the AES-128 encryption core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes128_pkg;

  // configuration register indexes
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam int unsigned NUM_ROUNDS = 10;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_word_t;

  // byte 0 sits at bits 127:120
  typedef logic [127:0] blk_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes and ShiftRows; byte index = column * 4 + row
  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4)*4 + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      a0  = get_byte(s, c*4);
      a1  = get_byte(s, c*4 + 1);
      a2  = get_byte(s, c*4 + 2);
      a3  = get_byte(s, c*4 + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(c*4)     -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[127 - 8*(c*4 + 1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[127 - 8*(c*4 + 2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[127 - 8*(c*4 + 3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // next round key from the previous one
  function automatic blk_t next_key(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // round key r of the all-zero key, used as the reset value of the schedule
  function automatic blk_t zero_round_key(input int unsigned r);
    blk_t k;
    k = '0;
    for (int unsigned i = 1; i <= r; i++) begin
      k = next_key(k, RCON[i]);
    end
    zero_round_key = k;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/aes128_block_encrypt.sv */
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// Fully pipelined AES-128 encryption, one round per stage.
// ----------------------------------------------------------------------------
// One 128-bit word enters per cycle unless in_stall is high; its result is
// presented on the output once it has passed the initial AddRoundKey stage and
// ten round stages, the last of which is the output register. Throughput is
// one word per clock without back-pressure; an output stall holds only the full
// stages with no empty stage ahead; input is taken while an empty stage lies
// ahead. The round keys ripple forward one stage per cycle in a register chain
// that no stall holds, so words may be offered from the cycle after the last key
// write; the key must only be changed while the pipe is empty.
`default_nettype none

module aes128_block_encrypt (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire                       cfg_index,
  input  wire [63:0]                cfg_data,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire aes128_pkg::in_word_t in_word,
  output logic                      out_valid,
  input  wire                       out_stall,
  output aes128_pkg::out_word_t     out_word
);

  localparam int unsigned NR = aes128_pkg::NUM_ROUNDS;

  // key registers and round-key chain (rk_r[r] is round key r)
  logic [63:0]        key_high_r, key_low_r;
  aes128_pkg::blk_t   key_blk;
  aes128_pkg::blk_t   rk_r [1:NR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == aes128_pkg::REG_KEY_HIGH) key_high_r <= cfg_data;
      if (cfg_index == aes128_pkg::REG_KEY_LOW)  key_low_r  <= cfg_data;
    end
  end

  assign key_blk = {key_high_r, key_low_r};

  // one key-schedule step per register; reset loads the zero-key schedule
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned r = 1; r <= NR; r++) begin
        rk_r[r] <= aes128_pkg::zero_round_key(r);
      end
    end else begin
      rk_r[1] <= aes128_pkg::next_key(key_blk, aes128_pkg::RCON[1]);
      for (int unsigned r = 2; r <= NR; r++) begin
        rk_r[r] <= aes128_pkg::next_key(rk_r[r-1], aes128_pkg::RCON[r]);
      end
    end
  end

  // datapath stages: stage 0 whitening, stages 1..NR rounds
  aes128_pkg::blk_t st_r  [NR+1];
  logic [NR:0]      vld_r;
  logic [NR:0]      adv;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NR] = !vld_r[NR] || !out_stall;
    for (int i = NR - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int unsigned i = 1; i <= NR; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) st_r[0] <= {in_word.plain_high, in_word.plain_low} ^ key_blk;
    for (int unsigned i = 1; i < NR; i++) begin
      if (adv[i]) begin
        st_r[i] <= aes128_pkg::mix_columns(aes128_pkg::sub_shift(st_r[i-1])) ^ rk_r[i];
      end
    end
    if (adv[NR]) st_r[NR] <= aes128_pkg::sub_shift(st_r[NR-1]) ^ rk_r[NR];
  end

  assign out_valid            = vld_r[NR];
  assign out_word.cipher_high = st_r[NR][127:64];
  assign out_word.cipher_low  = st_r[NR][63:0];

  // a stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed under stall");

  // an accepted word is captured in stage 0
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted word not captured");

  // the pipe only refuses input when every stage is full and the output stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0] && out_valid && out_stall)
    else $error("input stalled without back-pressure");

endmodule

`default_nettype wire
